// ===== hdl/mrm_pkg.sv =====
// shared constants, types and helpers of the murmurhash2 string hash block
package mrm_pkg;

   localparam logic [31:0] MIX_MULT = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT = 24;
   localparam int unsigned AVAL_SHIFT_A = 13;
   localparam int unsigned AVAL_SHIFT_B = 15;

   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_SEED_IDX = 1'b0;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FULL,
      KIND_TAIL
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        first;
      logic        last;
      logic [31:0] key;
      logic [31:0] init;
   } entry_type;

   // low half of the product only
   function automatic logic [31:0] mul_m(input logic [31:0] a);
      return a * MIX_MULT;
   endfunction

endpackage

// ===== hdl/mrm_req_if.sv =====
// word beat channel into the hash block
interface mrm_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        first_word;
   logic        last_word;
   logic [31:0] message_length;

   modport source (
      output valid, data_word, byte_count, first_word, last_word, message_length,
      input  ready
   );
   modport sink (
      input  valid, data_word, byte_count, first_word, last_word, message_length,
      output ready
   );
endinterface

// ===== hdl/mrm_rsp_if.sv =====
// hash result beat channel out of the hash block
interface mrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;

   modport source (
      output valid, hash_value,
      input  ready
   );
   modport sink (
      input  valid, hash_value,
      output ready
   );
endinterface

// ===== hdl/mrm_front.sv =====
// front end: accepts word beats, classifies them and pipelines the key mix
module mrm_front (
   input  logic               clock,
   input  logic               reset,
   mrm_req_if.sink            req_chan,
   input  logic [31:0]        seed,
   output mrm_pkg::entry_type push_entry,
   output logic               push_valid,
   input  logic               push_ready
);
   import mrm_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   kind_type    s1_kind_ff;
   logic        s1_first_ff;
   logic        s1_last_ff;
   logic [31:0] s1_val_ff;
   logic [31:0] s1_init_ff;

   logic        s2_valid_ff, s2_valid_in;
   entry_type   s2_entry_ff, s2_entry_in;

   logic        s1_take;
   logic        s2_take;
   logic        req_fire;
   kind_type    kind_in;
   logic [31:0] tail_mask;
   logic [31:0] s1_val_in;
   logic [31:0] fold;

   assign s2_take = !s2_valid_ff || push_ready;
   assign s1_take = !s1_valid_ff || s2_take;
   assign req_chan.ready = s1_take;
   assign req_fire = req_chan.valid && s1_take;

   // classify the beat by its byte count
   always_comb begin
      tail_mask = 32'h0000_0000;
      if (req_chan.byte_count[2]) begin
         kind_in = KIND_FULL;
      end else begin
         unique case (req_chan.byte_count[1:0])
            2'd0: kind_in = KIND_NONE;
            2'd1: begin
               kind_in   = KIND_TAIL;
               tail_mask = 32'h0000_00ff;
            end
            2'd2: begin
               kind_in   = KIND_TAIL;
               tail_mask = 32'h0000_ffff;
            end
            default: begin
               kind_in   = KIND_TAIL;
               tail_mask = 32'h00ff_ffff;
            end
         endcase
      end
   end

   assign s1_val_in = (kind_in == KIND_FULL) ? mul_m(req_chan.data_word)
                                             : (req_chan.data_word & tail_mask);

   assign s1_valid_in = s1_take ? req_chan.valid : s1_valid_ff;

   // second half of the key mix
   assign fold = s1_val_ff ^ (s1_val_ff >> MIX_SHIFT);
   always_comb begin
      s2_entry_in.kind  = s1_kind_ff;
      s2_entry_in.first = s1_first_ff;
      s2_entry_in.last  = s1_last_ff;
      s2_entry_in.key   = (s1_kind_ff == KIND_FULL) ? mul_m(fold) : s1_val_ff;
      s2_entry_in.init  = s1_init_ff;
   end

   assign s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (req_fire) begin
         s1_kind_ff  <= kind_in;
         s1_first_ff <= req_chan.first_word;
         s1_last_ff  <= req_chan.last_word;
         s1_val_ff   <= s1_val_in;
         s1_init_ff  <= seed ^ req_chan.message_length;
      end
      if (s2_take && s1_valid_ff) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

   assign push_valid = s2_valid_ff;
   assign push_entry = s2_entry_ff;

endmodule

// ===== hdl/mrm_queue.sv =====
// short queue of classified beats between front and back
module mrm_queue #(
   parameter int DEPTH = mrm_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  mrm_pkg::entry_type push_entry,
   input  logic               push_valid,
   output logic               push_ready,
   output mrm_pkg::entry_type pop_entry,
   output logic               pop_valid,
   input  logic               pop_ready
);
   import mrm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;
   assign pop_entry = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("queue empty with pointers apart");

endmodule

// ===== hdl/mrm_back.sv =====
// back end: accumulator update, avalanche and result register
module mrm_back (
   input  logic               clock,
   input  logic               reset,
   input  mrm_pkg::entry_type pop_entry,
   input  logic               pop_valid,
   output logic               pop_ready,
   mrm_rsp_if.source          rsp_chan
);
   import mrm_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic        fin_valid_ff, fin_valid_in;
   logic [31:0] fin_hash_ff;
   logic        av_valid_ff, av_valid_in;
   logic [31:0] av_prod_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_hash_ff;

   logic        out_take;
   logic        av_take;
   logic        fin_take;
   logic        pop_fire;
   logic [31:0] h_start;
   logic [31:0] mul_arg;
   logic [31:0] mul_res;
   logic [31:0] av_fold;

   assign out_take  = !out_valid_ff || rsp_chan.ready;
   assign av_take   = !av_valid_ff || out_take;
   assign fin_take  = !fin_valid_ff || av_take;
   assign pop_ready = fin_take;
   assign pop_fire  = pop_valid && fin_take;

   // one multiply on the accumulator loop
   assign h_start = pop_entry.first ? pop_entry.init : acc_ff;
   assign mul_arg = (pop_entry.kind == KIND_TAIL) ? (h_start ^ pop_entry.key) : h_start;
   assign mul_res = mul_m(mul_arg);

   always_comb begin
      unique case (pop_entry.kind)
         KIND_FULL: acc_in = mul_res ^ pop_entry.key;
         KIND_TAIL: acc_in = mul_res;
         default:   acc_in = h_start;
      endcase
   end

   assign av_fold = fin_hash_ff ^ (fin_hash_ff >> AVAL_SHIFT_A);

   assign fin_valid_in = fin_take ? (pop_fire && pop_entry.last) : fin_valid_ff;
   assign av_valid_in  = av_take ? fin_valid_ff : av_valid_ff;
   assign out_valid_in = out_take ? av_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
         av_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop_fire) begin
            acc_ff <= acc_in;
         end
         fin_valid_ff <= fin_valid_in;
         av_valid_ff  <= av_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (pop_fire) begin
         fin_hash_ff <= acc_in;
      end
      if (av_take && fin_valid_ff) begin
         av_prod_ff <= mul_m(av_fold);
      end
      if (out_take && av_valid_ff) begin
         out_hash_ff <= av_prod_ff ^ (av_prod_ff >> AVAL_SHIFT_B);
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.hash_value = out_hash_ff;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_hash_ff)))
      else $error("result beat dropped under stall");

   a_fin_feeds: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && av_take) |=> av_valid_ff)
      else $error("final hash lost before avalanche");

   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      !pop_fire |=> $stable(acc_ff))
      else $error("accumulator moved without a beat");

endmodule

// ===== hdl/murmur2_string_hash.sv =====
// top level of the murmurhash2 string hash block
//
// req_chan carries one 32-bit little-endian message word per beat with its
// byte count, first/last marks and, on the first word, the total length.
// rsp_chan carries one 32-bit hash per message, after its last word.
// the seed register sits at byte address 0 of the apb-style port.
// words are taken one per cycle unless a stall backs up into the input; the
// accumulator loop holds one constant multiply per word, the key mix runs in
// a two-stage front pipeline. from the last word's beat, the hash passes the
// two front stages, the queue, the accumulator, the avalanche multiply and
// the output register.
// a short queue parts the front from the back, and the result sits in an
// output register, so a stalled receiver backs up the queue and then the
// input while items already inside are held without loss.
// reset clears the pipelines, the queue, the accumulator and the seed.
module murmur2_string_hash #(
   parameter int QUEUE_DEPTH = mrm_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   mrm_req_if.sink                       req_chan,
   mrm_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mrm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import mrm_pkg::*;

   logic [31:0] seed_ff;
   logic        csr_write;
   logic        seed_sel;
   entry_type   push_entry;
   logic        push_valid;
   logic        push_ready;
   entry_type   pop_entry;
   logic        pop_valid;
   logic        pop_ready;

   assign pready    = 1'b1;
   assign seed_sel  = paddr[CSR_ADDR_W-1] == CSR_SEED_IDX;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = seed_sel ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_write && seed_sel) begin
         seed_ff <= pwdata;
      end
   end

   mrm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .seed       (seed_ff),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   mrm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   mrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== verif/mrm_hash_checker.sv =====
// checker for the murmurhash2 block: predicts each message hash and compares result beats
module mrm_hash_checker (
   input  logic                           clock,
   input  logic                           reset,
   mrm_req_if                             req_mon,
   mrm_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mrm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   input  logic [31:0]                    prdata,
   input  logic                           pready,
   output int unsigned                    hashes_due,
   output int unsigned                    mismatch_count
);
   import mrm_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = CSR_ADDR_W'(4 * CSR_SEED_IDX);

   logic [31:0] seed_copy;
   logic [31:0] running_hash;
   logic [31:0] hash_expected[$];

   function automatic logic [31:0] scramble_key(input logic [31:0] w);
      logic [31:0] k;
      k = w * MIX_MULT;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MULT;
      return k;
   endfunction

   function automatic logic [31:0] final_mix(input logic [31:0] h);
      logic [31:0] v;
      v = h ^ (h >> AVAL_SHIFT_A);
      v = v * MIX_MULT;
      v = v ^ (v >> AVAL_SHIFT_B);
      return v;
   endfunction

   always @(posedge clock) begin : monitor
      logic [31:0] h;
      logic [31:0] want;
      if (reset) begin
         seed_copy = '0;
         running_hash = '0;
         hash_expected.delete();
         hashes_due = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (hash_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected hash beat: expected none, actual %h",
                        $time, rsp_mon.hash_value);
            end else begin
               want = hash_expected.pop_front();
               hashes_due--;
               if (rsp_mon.hash_value !== want) begin
                  mismatch_count++;
                  $display("%0t hash_value mismatch: expected %h, actual %h",
                           $time, want, rsp_mon.hash_value);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.first_word)
               running_hash = seed_copy ^ req_mon.message_length;
            h = running_hash;
            if (req_mon.byte_count >= 3'd4) begin
               h = (h * MIX_MULT) ^ scramble_key(req_mon.data_word);
            end else if (req_mon.byte_count != 3'd0) begin
               h = h ^ (req_mon.data_word & ~(32'hffffffff << (8 * req_mon.byte_count)));
               h = h * MIX_MULT;
            end
            running_hash = h;
            if (req_mon.last_word) begin
               hash_expected.push_back(final_mix(h));
               hashes_due++;
            end
         end
         if (psel && penable && pready && paddr == SEED_ADDR) begin
            if (pwrite) begin
               seed_copy = pwdata;
            end else if (prdata !== seed_copy) begin
               mismatch_count++;
               $display("%0t seed readback mismatch: expected %h, actual %h",
                        $time, seed_copy, prdata);
            end
         end
      end
   end

endmodule

// ===== verif/tb_murmur2_string_hash.sv =====
// testbench top for the murmurhash2 block: clock, reset, word stimulus, seed writes, verdict
module tb_murmur2_string_hash;
   import mrm_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = CSR_ADDR_W'(4 * CSR_SEED_IDX);
   localparam int unsigned WORDS_PER_PHASE = 180;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 80;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   int unsigned hashes_due;
   int unsigned mismatch_count;
   int unsigned words_sent;
   int unsigned idle_cycles;
   bit          quiet;
   bit          long_hold;

   mrm_req_if req_bus ();
   mrm_rsp_if rsp_bus ();

   murmur2_string_hash dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mrm_hash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .hashes_due     (hashes_due),
      .mismatch_count (mismatch_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : receiver
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (long_hold) begin
            long_hold = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   task automatic push_word(input logic [31:0] word, input logic [2:0] count,
                            input logic first, input logic last,
                            input logic [31:0] length);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.data_word = word;
      req_bus.byte_count = count;
      req_bus.first_word = first;
      req_bus.last_word = last;
      req_bus.message_length = length;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   task automatic send_message(input int unsigned n, input logic [31:0] length);
      int unsigned words;
      if (n == 0) begin
         push_word($urandom, 3'd0, 1'b1, 1'b1, length);
      end else begin
         words = (n + 3) / 4;
         for (int unsigned i = 0; i < words; i++)
            push_word($urandom, (i == words - 1) ? 3'(n - 4 * i) : 3'd4,
                      i == 0, i == words - 1, (i == 0) ? length : $urandom);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (hashes_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = write;
      paddr = SEED_ADDR;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_seed(input logic [31:0] value);
      drain();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
   endtask

   task automatic random_traffic(input int unsigned budget);
      int unsigned start;
      int unsigned r;
      int unsigned n;
      start = words_sent;
      while (words_sent - start < budget) begin
         quiet = ($urandom_range(0, 9) == 0);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            push_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), $urandom);
         end else if (r < 12) begin
            // short or empty word in the middle of a message
            push_word($urandom, 3'd4, 1'b1, 1'b0, $urandom_range(0, 16));
            push_word($urandom, 3'($urandom_range(0, 3)), 1'b0, 1'b0, $urandom);
            push_word($urandom, 3'($urandom_range(1, 4)), 1'b0, 1'b1, $urandom);
         end else if (r < 16) begin
            send_message($urandom_range(0, 12), $urandom);
         end else if (r < 20) begin
            n = $urandom_range(13, 40);
            send_message(n, n);
         end else begin
            n = $urandom_range(0, 12);
            send_message(n, n);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_word = '0;
      req_bus.byte_count = '0;
      req_bus.first_word = 1'b0;
      req_bus.last_word = 1'b0;
      req_bus.message_length = '0;
      words_sent = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      long_hold = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // word without a first word straight after reset
      push_word($urandom, 3'd4, 1'b0, 1'b1, $urandom);
      set_seed(32'h0);
      send_message(0, 32'h0);
      send_message(0, 32'hffffffff);
      push_word(32'hffffffff, 3'd1, 1'b1, 1'b1, 32'd1);
      push_word(32'hffffffff, 3'd2, 1'b1, 1'b1, 32'd2);
      push_word(32'hffffffff, 3'd3, 1'b1, 1'b1, 32'd3);
      push_word(32'h00000000, 3'd4, 1'b1, 1'b1, 32'd4);
      push_word(32'hffffffff, 3'd4, 1'b1, 1'b1, 32'd4);
      push_word(32'ha5a5a5a5, 3'd7, 1'b1, 1'b1, 32'd4);
      push_word(32'h5a5a5a5a, 3'd5, 1'b1, 1'b1, 32'd4);
      // zero-byte word mid-message
      push_word($urandom, 3'd4, 1'b1, 1'b0, 32'd8);
      push_word($urandom, 3'd0, 1'b0, 1'b0, $urandom);
      push_word($urandom, 3'd4, 1'b0, 1'b1, $urandom);
      // tail word that is not last
      push_word($urandom, 3'd2, 1'b1, 1'b0, 32'd6);
      push_word($urandom, 3'd4, 1'b0, 1'b1, $urandom);
      // continuing without a first word
      push_word($urandom, 3'd4, 1'b0, 1'b1, $urandom);
      // length that disagrees with the words
      push_word($urandom, 3'd4, 1'b1, 1'b1, 32'd1000);
      send_message(5, 5);
      set_seed(32'hffffffff);
      send_message(0, 32'h0);
      send_message(3, 3);
      send_message(8, 8);

      set_seed(32'h0);
      random_traffic(WORDS_PER_PHASE);

      set_seed(32'hffffffff);
      // receiver holds off while the sender keeps offering beats
      long_hold = 1'b1;
      quiet = 1'b1;
      for (int i = 0; i < 20; i++)
         send_message($urandom_range(4, 8), $urandom_range(4, 8));
      quiet = 1'b0;
      drain();
      random_traffic(WORDS_PER_PHASE);

      set_seed($urandom);
      random_traffic(WORDS_PER_PHASE);

      set_seed(32'h1);
      random_traffic(WORDS_PER_PHASE);

      set_seed($urandom);
      random_traffic(WORDS_PER_PHASE);

      drain();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && hashes_due == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
